### hw/rtl/ipid_pkg.sv
// Package for the incremental PID loop: configuration and command types,
// register indexes, loop modes and fixed-point limits.
// Used by every module of the block; depends on nothing.
package ipid_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CURRENT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DUTY    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DUTY    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_MODE   = 3'd6;

  // Loop modes. The unused code behaves as position mode.
  localparam logic [1:0] MODE_CURRENT  = 2'd0;
  localparam logic [1:0] MODE_SPEED    = 2'd1;
  localparam logic [1:0] MODE_POSITION = 2'd2;

  // Output limit of +-10.0 in Q4.12 and the duty scale factor.
  localparam logic signed [30:0] OutLimit  = 31'sd40960;
  localparam logic signed [19:0] DutyScale = 20'sd420;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [14:0] max_current;
    logic [15:0] max_duty;
    logic [15:0] min_duty;
    logic [1:0]  loop_mode;
  } cfg_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    OP_PROP  = 2'd0,
    OP_INTEG = 2'd1,
    OP_DERIV = 2'd2,
    OP_SCALE = 2'd3
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    mul_en;
    mul_op_e mul_op;
    logic    clamp_en;
    logic    finish_en;
  } dp_cmd_t;

endpackage

### hw/rtl/ipid_cfg_regs.sv
// Configuration register file of the incremental PID loop.
// Depends on ipid_pkg for the register indexes and the cfg_t struct.
module ipid_cfg_regs
  import ipid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Single write port; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= 16'd4096;
      cfg_q.integ_gain  <= 16'd0;
      cfg_q.deriv_gain  <= 16'd0;
      cfg_q.max_current <= 15'd32767;
      cfg_q.max_duty    <= 16'd4190;
      cfg_q.min_duty    <= 16'd10;
      cfg_q.loop_mode   <= MODE_CURRENT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_wdata_i;
        CFG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_wdata_i;
        CFG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_wdata_i;
        CFG_MAX_CURRENT: cfg_q.max_current <= cfg_wdata_i[14:0];
        CFG_MAX_DUTY:    cfg_q.max_duty    <= cfg_wdata_i;
        CFG_MIN_DUTY:    cfg_q.min_duty    <= cfg_wdata_i;
        CFG_LOOP_MODE:   cfg_q.loop_mode   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/ipid_ctrl.sv
// Sequencer of the incremental PID loop: steps one item through the shared
// multiplier, the clamp and the output register. Depends on ipid_pkg.
module ipid_ctrl
  import ipid_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_P  = 3'd1;
  localparam logic [2:0] ST_MUL_I  = 3'd2;
  localparam logic [2:0] ST_MUL_D  = 3'd3;
  localparam logic [2:0] ST_CLAMP  = 3'd4;
  localparam logic [2:0] ST_SCALE  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can be loaded when it is empty or being emptied.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d          = state_q;
    cmd_o.load_in    = 1'b0;
    cmd_o.mul_en     = 1'b0;
    cmd_o.mul_op     = OP_PROP;
    cmd_o.clamp_en   = 1'b0;
    cmd_o.finish_en  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = OP_PROP;
        state_d      = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = OP_INTEG;
        state_d      = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = OP_DERIV;
        state_d      = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.clamp_en = 1'b1;
        state_d        = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = OP_SCALE;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish_en = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish_en) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/ipid_datapath.sv
// Datapath of the incremental PID loop: error terms, one shared multiplier,
// accumulator, output clamp, duty scaling and the output register.
// Depends on ipid_pkg for cfg_t, dp_cmd_t, modes and limits.
module ipid_datapath
  import ipid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  dp_cmd_t             cmd_i,
  input  logic signed [15:0]  setpoint_i,
  input  logic signed [15:0]  measured_i,
  output logic signed [16:0]  control_out_o,
  output logic [15:0]         duty_count_o,
  output logic                direction_o
);

  // Loop state.
  logic signed [17:0] e0_q, e1_q, e2_q;
  logic signed [16:0] prev_q;
  logic               dir_q;

  // Working registers.
  logic signed [37:0] acc_q;
  logic signed [16:0] result_q;
  logic signed [26:0] pw_q;

  // Output register.
  logic signed [16:0] ctl_out_q;
  logic [15:0]        duty_q;
  logic               dir_out_q;

  logic signed [16:0] fb;
  logic signed [17:0] e0_d;
  logic signed [18:0] diff1;
  logic signed [19:0] diff2;
  logic signed [16:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [36:0] prod;
  logic signed [29:0] inc;
  logic signed [30:0] sum;
  logic signed [16:0] result_d;
  logic signed [29:0] pw_ext;
  logic signed [29:0] max_lim;
  logic signed [29:0] min_lim;
  logic [15:0]        duty_d;
  logic               dir_d;

  // Feedback conditioning by loop mode, then the new error.
  always_comb begin
    fb = {measured_i[15], measured_i};
    if (cfg_i.loop_mode == MODE_CURRENT) begin
      if (measured_i > $signed({1'b0, cfg_i.max_current})) begin
        fb = $signed({2'b00, cfg_i.max_current});
      end
    end else if (cfg_i.loop_mode == MODE_SPEED) begin
      fb = {measured_i, 1'b0};
    end
  end

  assign e0_d = {{2{setpoint_i[15]}}, setpoint_i} - {fb[16], fb};

  // First and second differences of the error.
  assign diff1 = {e0_q[17], e0_q} - {e1_q[17], e1_q};
  assign diff2 = {{2{e0_q[17]}}, e0_q} - {e1_q[17], e1_q, 1'b0}
               + {{2{e2_q[17]}}, e2_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.mul_op)
      OP_PROP: begin
        mul_a = $signed({1'b0, cfg_i.prop_gain});
        mul_b = {diff1[18], diff1};
      end
      OP_INTEG: begin
        mul_a = $signed({1'b0, cfg_i.integ_gain});
        mul_b = {{2{e0_q[17]}}, e0_q};
      end
      OP_DERIV: begin
        mul_a = $signed({1'b0, cfg_i.deriv_gain});
        mul_b = diff2;
      end
      default: begin
        mul_a = result_q;
        mul_b = DutyScale;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Increment is the Q.20 sum floored to Q4.12; then add and clamp.
  assign inc = acc_q[37:8];
  assign sum = {{14{prev_q[16]}}, prev_q} + {inc[29], inc};

  always_comb begin
    if (sum > OutLimit) begin
      result_d = OutLimit[16:0];
    end else if (sum < -OutLimit) begin
      result_d = 17'(-OutLimit);
    end else begin
      result_d = sum[16:0];
    end
  end

  // Duty count in current mode: upper limit first, then lower, else the floored count; zero in other modes.
  assign pw_ext  = {{3{pw_q[26]}}, pw_q};
  assign max_lim = $signed({2'b00, cfg_i.max_duty, 12'h000});
  assign min_lim = $signed({2'b00, cfg_i.min_duty, 12'h000});

  always_comb begin
    duty_d = 16'd0;
    if (cfg_i.loop_mode == MODE_CURRENT) begin
      if (pw_ext > max_lim) begin
        duty_d = cfg_i.max_duty;
      end else if (pw_ext < min_lim) begin
        duty_d = cfg_i.min_duty;
      end else begin
        duty_d = {1'b0, pw_q[26:12]};
      end
    end
  end

  // Direction follows the sign and holds on zero.
  always_comb begin
    dir_d = dir_q;
    if (result_q > 17'sd0) begin
      dir_d = 1'b1;
    end else if (result_q < 17'sd0) begin
      dir_d = 1'b0;
    end
  end

  // Loop state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q   <= '0;
      e2_q   <= '0;
      prev_q <= '0;
      dir_q  <= 1'b0;
    end else if (cmd_i.finish_en) begin
      e2_q   <= e1_q;
      e1_q   <= e0_q;
      prev_q <= result_q;
      dir_q  <= dir_d;
    end
  end

  // Working and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      e0_q <= e0_d;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_op)
        OP_PROP:  acc_q <= {prod[36], prod};
        OP_INTEG: acc_q <= acc_q + {prod[36], prod};
        OP_DERIV: acc_q <= acc_q + {prod[36], prod};
        default:  pw_q  <= prod[26:0];
      endcase
    end
    if (cmd_i.clamp_en) begin
      result_q <= result_d;
    end
    if (cmd_i.finish_en) begin
      ctl_out_q <= result_q;
      duty_q    <= duty_d;
      dir_out_q <= dir_d;
    end
  end

  assign control_out_o = ctl_out_q;
  assign duty_count_o  = duty_q;
  assign direction_o   = dir_out_q;

endmodule

### hw/rtl/incremental_pid_loop.sv
// Incremental PID loop controller, top level: configuration registers,
// sequencer and datapath. Depends on ipid_pkg, ipid_cfg_regs, ipid_ctrl
// and ipid_datapath.
//
// Usage: each input item is one loop sample (setpoint_i, measured_i, both
// signed Q8.8) handed over on the in_valid_i / in_ready_o channel. Each
// sample yields exactly one result item on out_valid_o / out_ready_i:
// control_out_o (signed Q4.12, clamped to +-10.0), duty_count_o (current
// mode only, else zero) and direction_o.
// Each sample passes three times through the single shared multiplier
// (P, I, D terms), then through the clamp, once more through the
// multiplier for the duty scaling and then into the output register.
// in_ready_o is high only while the sequencer is idle; a new sample may be
// taken while the previous result still waits in the output register.
// If the receiver stalls, the finished result holds the sequencer in its
// last step until the output register frees up; nothing is dropped.
// Reset clears the error history, previous output and direction to zero
// and loads the register defaults. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write them only while no sample
// is in flight, as the block itself does not enforce this.
module incremental_pid_loop
  import ipid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  setpoint_i,
  input  logic signed [15:0]  measured_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [16:0]  control_out_o,
  output logic [15:0]         duty_count_o,
  output logic                direction_o
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  // Configuration registers.
  ipid_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  ipid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and loop state.
  ipid_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .setpoint_i    (setpoint_i),
    .measured_i    (measured_i),
    .control_out_o (control_out_o),
    .duty_count_o  (duty_count_o),
    .direction_o   (direction_o)
  );

endmodule
